/* src/dq_pkg.sv */
// Shared types and constants for the double-ended queue.
package dq_pkg;

	localparam int unsigned DEPTH_DEF = 64;
	localparam int unsigned WORD_W    = 32;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_DUMP       = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

endpackage

/* src/dq_ram.sv */
// Entry store: one write port, one read port, registered read data.
module dq_ram
	import dq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF,
	parameter int unsigned IW    = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [IW-1:0]            waddr,
	input  logic signed [WORD_W-1:0] wdata,
	input  logic                     re,
	input  logic [IW-1:0]            raddr,
	output logic signed [WORD_W-1:0] rdata
);

	logic signed [WORD_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/double_ended_queue.sv */
// Double-ended queue of signed words in a ring store, with dump of all entries.
//
//  channel | signals                        | transfer when
//  --------+--------------------------------+-----------------------------
//  request | req_valid req_stall opcode value | req_valid && !req_stall
//  result  | rsp_valid rsp_stall data status last | rsp_valid && !rsp_stall
//
// Pushes and errors load the result register from the request. Pops read the entry
// store first and load its registered read data. Dump returns one entry per cycle,
// while the result is not stalled, from the store's single read port.
// Reset clears front index, count and rsp_valid, not result data or the store.
// A stalled result register holds requests and store reads off.
module double_ended_queue
	import dq_pkg::*;
#(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [2:0]               opcode,
	input  logic signed [WORD_W-1:0] value,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic signed [WORD_W-1:0] data,
	output logic [1:0]               status,
	output logic                     last
);

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	state_t          state_q, state_d;
	logic [IW-1:0]   front_q, front_d;
	logic [CW-1:0]   count_q, count_d;
	logic [IW-1:0]   pos_q, pos_d;
	logic [CW-1:0]   left_q, left_d;
	logic            pend_last_q, pend_last_d;

	logic                     rsp_valid_q;
	logic signed [WORD_W-1:0] data_q;
	status_t                  status_q;
	logic                     last_q;

	logic                     out_free;
	logic                     rsp_load;
	logic signed [WORD_W-1:0] load_data;
	status_t                  load_status;
	logic                     load_last;

	logic                     we, re;
	logic [IW-1:0]            waddr, raddr;
	logic signed [WORD_W-1:0] rdata;

	logic [CW:0]   back_sum, tail_sum;
	logic [IW-1:0] back_slot, tail_slot, front_inc, front_dec, pos_inc;
	logic          full, empty;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);

	assign back_sum  = (CW+1)'(front_q) + (CW+1)'(count_q);
	assign back_slot = (back_sum >= (CW+1)'(DEPTH)) ? IW'(back_sum - (CW+1)'(DEPTH))
		: IW'(back_sum);
	assign tail_sum  = back_sum - (CW+1)'(1);
	assign tail_slot = (tail_sum >= (CW+1)'(DEPTH)) ? IW'(tail_sum - (CW+1)'(DEPTH))
		: IW'(tail_sum);
	assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);
	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
	assign pos_inc   = (pos_q == IW'(DEPTH - 1)) ? '0 : pos_q + IW'(1);

	assign out_free = !rsp_valid_q || !rsp_stall;

	dq_ram #(
		.DEPTH (DEPTH),
		.IW    (IW)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d     = state_q;
		front_d     = front_q;
		count_d     = count_q;
		pos_d       = pos_q;
		left_d      = left_q;
		pend_last_d = pend_last_q;
		rsp_load    = 1'b0;
		load_data   = '0;
		load_status = ST_OK;
		load_last   = 1'b1;
		we          = 1'b0;
		waddr       = back_slot;
		re          = 1'b0;
		raddr       = front_q;
		req_stall   = !((state_q == S_IDLE) && out_free);
		unique case (state_q)
			S_IDLE: begin
				if (req_valid && out_free) begin
					unique case (op_t'(opcode))
						OP_PUSH_BACK, OP_PUSH_FRONT: begin
							rsp_load = 1'b1;
							if (full) begin
								load_status = ST_FULL;
							end else begin
								we      = 1'b1;
								count_d = count_q + CW'(1);
								if (op_t'(opcode) == OP_PUSH_FRONT) begin
									waddr   = front_dec;
									front_d = front_dec;
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (empty) begin
								rsp_load    = 1'b1;
								load_status = ST_EMPTY;
							end else begin
								re          = 1'b1;
								count_d     = count_q - CW'(1);
								left_d      = '0;
								pend_last_d = 1'b1;
								state_d     = S_READ;
								if (op_t'(opcode) == OP_POP_FRONT) begin
									front_d = front_inc;
								end else begin
									raddr = tail_slot;
								end
							end
						end
						OP_DUMP: begin
							if (empty) begin
								rsp_load    = 1'b1;
								load_status = ST_EMPTY;
							end else begin
								re          = 1'b1;
								pos_d       = front_inc;
								left_d      = count_q - CW'(1);
								pend_last_d = (count_q == CW'(1));
								state_d     = S_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				if (out_free) begin
					rsp_load  = 1'b1;
					load_data = rdata;
					load_last = pend_last_q;
					if (left_q != '0) begin
						re          = 1'b1;
						raddr       = pos_q;
						pos_d       = pos_inc;
						left_d      = left_q - CW'(1);
						pend_last_d = (left_q == CW'(1));
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			left_q      <= '0;
			pend_last_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			front_q     <= front_d;
			count_q     <= count_d;
			pos_q       <= pos_d;
			left_q      <= left_d;
			pend_last_q <= pend_last_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			data_q   <= load_data;
			status_q <= load_status;
			last_q   <= load_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign data      = data_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule
